// ----- hw/rtl/vss_pkg.sv -----
// Shared constants and types for the slot signature scanner.
`timescale 1ns / 1ps

package vss_pkg;

    localparam int SLOT_BYTES  = 72;
    localparam int OFFSET_BITS = 32;
    localparam int ADDR_W      = 32;
    localparam int FILL_W      = $clog2(2 * SLOT_BYTES + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [7:0] PAIR_HI   = 8'h53;  // 'S'
    localparam logic [7:0] PAIR_LO   = 8'h43;  // 'C'
    localparam logic [7:0] TAG_BYTE  = 8'h2D;
    localparam int         HDR_LEN   = 4;

    localparam logic [ADDR_W-1:0] MASK_OFS     = ADDR_W'(328);
    localparam logic [ADDR_W-1:0] DEST_OFS     = ADDR_W'(344);
    localparam logic [ADDR_W-1:0] VALUE_OFS    = ADDR_W'(348);
    localparam logic [ADDR_W-1:0] MODIFIER_OFS = ADDR_W'(355);

    // One queue entry: the slots found on one input byte.
    typedef struct packed {
        logic                   two;
        logic [OFFSET_BITS-1:0] off0;
        logic [OFFSET_BITS-1:0] off1;
    } slot_entry_t;

endpackage

// ----- hw/rtl/vss_front.sv -----
// Front end: byte window, match detection and run tracking.
`timescale 1ns / 1ps

module vss_front
    import vss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        q_full,
    output logic        q_push,
    output slot_entry_t q_entry
);

    logic [7:0]             win_reg [SLOT_BYTES];
    logic [7:0]             win_next [SLOT_BYTES];
    logic [SLOT_BYTES-1:0]  hist_reg;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] nxt_off_reg, nxt_off_next;
    logic                   in_run_reg, in_run_next;
    logic [FILL_W-1:0]      fill_reg, fill_next;

    logic                   fire;
    logic                   hdr_ok, pair_ok, tag_ok, cur_match;
    logic [OFFSET_BITS-1:0] count, wstart, cand;

    assign in_ready = !q_full;
    assign fire     = in_valid && in_ready;

    always_comb
    begin
        for (int i = 0; i < SLOT_BYTES - 1; i++)
        begin
            win_next[i] = win_reg[i + 1];
        end
        win_next[SLOT_BYTES-1] = data_byte;
    end

    // Parallel compares over the incoming window.
    always_comb
    begin
        hdr_ok  = 1'b1;
        pair_ok = 1'b0;
        tag_ok  = 1'b0;
        for (int i = 0; i < HDR_LEN; i++)
        begin
            hdr_ok = hdr_ok && (win_next[i] == HDR_BYTE);
        end
        for (int i = 0; i < SLOT_BYTES - 1; i++)
        begin
            pair_ok = pair_ok || ((win_next[i] == PAIR_HI) && (win_next[i + 1] == PAIR_LO));
        end
        for (int i = 0; i < SLOT_BYTES; i++)
        begin
            tag_ok = tag_ok || (win_next[i] == TAG_BYTE);
        end
    end

    always_comb
    begin
        count       = offset_reg + OFFSET_BITS'(1);
        wstart      = count - OFFSET_BITS'(SLOT_BYTES);
        cand        = count - OFFSET_BITS'(2 * SLOT_BYTES);
        fill_next   = (fill_reg < FILL_W'(2 * SLOT_BYTES)) ? fill_reg + FILL_W'(1) : fill_reg;
        cur_match   = hdr_ok && pair_ok && tag_ok && (fill_next >= FILL_W'(SLOT_BYTES));
        offset_next = count;
        nxt_off_next = nxt_off_reg;
        in_run_next  = in_run_reg;
        q_push       = 1'b0;
        q_entry.two  = 1'b0;
        q_entry.off0 = wstart;
        q_entry.off1 = wstart;
        if (fill_next >= FILL_W'(SLOT_BYTES))
        begin
            if (in_run_reg)
            begin
                if (wstart == nxt_off_reg)
                begin
                    if (cur_match)
                    begin
                        q_push       = fire;
                        nxt_off_next = nxt_off_reg + OFFSET_BITS'(SLOT_BYTES);
                    end
                    else
                    begin
                        in_run_next = 1'b0;
                    end
                end
            end
            else if ((fill_next >= FILL_W'(2 * SLOT_BYTES)) && (cand[1:0] == 2'b00) &&
                     (cand >= nxt_off_reg) && hist_reg[0] && cur_match)
            begin
                q_push       = fire;
                q_entry.two  = 1'b1;
                q_entry.off0 = cand;
                in_run_next  = 1'b1;
                nxt_off_next = cand + OFFSET_BITS'(2 * SLOT_BYTES);
            end
        end
    end

    // Window and history carry no reset: the fill count gates every use.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            win_reg  <= win_next;
            hist_reg <= {cur_match, hist_reg[SLOT_BYTES-1:1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            nxt_off_reg <= '0;
            in_run_reg  <= 1'b0;
            fill_reg    <= '0;
        end
        else if (fire)
        begin
            if (last_byte)
            begin
                offset_reg  <= '0;
                nxt_off_reg <= '0;
                in_run_reg  <= 1'b0;
                fill_reg    <= '0;
            end
            else
            begin
                offset_reg  <= offset_next;
                nxt_off_reg <= nxt_off_next;
                in_run_reg  <= in_run_next;
                fill_reg    <= fill_next;
            end
        end
    end

endmodule

// ----- hw/rtl/vss_queue.sv -----
// Short FIFO of found-slot entries between front and back ends.
`timescale 1ns / 1ps

module vss_queue
    import vss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  slot_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        head_valid,
    output slot_entry_t head_entry
);

    slot_entry_t         mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_push, do_pop;

    assign full       = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        cnt_next = cnt_reg;
        case ({do_push, do_pop})
            2'b10:   cnt_next = cnt_reg + QCNT_W'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_W'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ----- hw/rtl/vss_back.sv -----
// Back end: base register and address generation into the output register.
`timescale 1ns / 1ps

module vss_back
    import vss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic              head_valid,
    input  slot_entry_t       head_entry,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] slot_base,
    output logic [ADDR_W-1:0] mask_addr,
    output logic [ADDR_W-1:0] dest_addr,
    output logic [ADDR_W-1:0] value_addr,
    output logic [ADDR_W-1:0] modifier_addr,
    output logic              final_of_item
);

    // Base plus each field offset, folded at write time.
    logic [ADDR_W-1:0] base_reg, mask_b_reg, dest_b_reg, value_b_reg, mod_b_reg;
    logic              idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0] slot_base_reg, mask_addr_reg, dest_addr_reg;
    logic [ADDR_W-1:0] value_addr_reg, modifier_addr_reg;
    logic              final_reg;
    logic              load, last_slot;
    logic [ADDR_W-1:0] off;

    assign cfg_ready = 1'b1;
    assign load      = head_valid && (!out_valid_reg || out_ready);
    assign last_slot = !head_entry.two || idx_reg;
    assign pop       = load && last_slot;
    assign off       = idx_reg ? ADDR_W'(head_entry.off1) : ADDR_W'(head_entry.off0);

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = !last_slot;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= '0;
            mask_b_reg  <= MASK_OFS;
            dest_b_reg  <= DEST_OFS;
            value_b_reg <= VALUE_OFS;
            mod_b_reg   <= MODIFIER_OFS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            base_reg    <= cfg_data;
            mask_b_reg  <= cfg_data + MASK_OFS;
            dest_b_reg  <= cfg_data + DEST_OFS;
            value_b_reg <= cfg_data + VALUE_OFS;
            mod_b_reg   <= cfg_data + MODIFIER_OFS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            slot_base_reg     <= base_reg + off;
            mask_addr_reg     <= mask_b_reg + off;
            dest_addr_reg     <= dest_b_reg + off;
            value_addr_reg    <= value_b_reg + off;
            modifier_addr_reg <= mod_b_reg + off;
            final_reg         <= last_slot;
        end
    end

    assign out_valid     = out_valid_reg;
    assign slot_base     = slot_base_reg;
    assign mask_addr     = mask_addr_reg;
    assign dest_addr     = dest_addr_reg;
    assign value_addr    = value_addr_reg;
    assign modifier_addr = modifier_addr_reg;
    assign final_of_item = final_reg;

endmodule

// ----- hw/rtl/var_slot_signature_scanner_top.sv -----
// Top level of the slot signature scanner.
// Input channel: in_valid/in_ready carry one buffer byte per beat (data_byte,
// last_byte). last_byte ends the buffer; the scan restarts at offset zero on
// the next beat.
// Config channel: cfg_valid/cfg_ready write base_address (cfg_data); always
// ready. The user must write only while the block is idle (unenforced).
// Output channel: out_valid/out_ready carry one found slot per beat with its
// base and four field addresses; final_of_item marks the last slot that one
// input byte produced.
// Throughput: one input byte per cycle while the queue is not full. The
// front end updates its 72-byte window and run state in the accept cycle
// and queues any found slots at the accepting edge. The queue head moves
// on into the output register when that is empty or being taken. A byte
// that opens a run yields two beats; a four-entry queue absorbs that.
// Receiver stall: the output register holds its beat, the queue fills, and
// in_ready drops once the queue is full.
// Reset: clears run state, counters, the queue and the output valid;
// base_address returns to zero.
`timescale 1ns / 1ps

module var_slot_signature_scanner_top
    import vss_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [ADDR_W-1:0] cfg_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [ADDR_W-1:0] slot_base,
    output logic [ADDR_W-1:0] mask_addr,
    output logic [ADDR_W-1:0] dest_addr,
    output logic [ADDR_W-1:0] value_addr,
    output logic [ADDR_W-1:0] modifier_addr,
    output logic              final_of_item
);

    logic        q_full, q_push, q_pop, q_head_valid;
    slot_entry_t q_entry, q_head;

    vss_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    vss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    vss_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .head_valid    (q_head_valid),
        .head_entry    (q_head),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .slot_base     (slot_base),
        .mask_addr     (mask_addr),
        .dest_addr     (dest_addr),
        .value_addr    (value_addr),
        .modifier_addr (modifier_addr),
        .final_of_item (final_of_item)
    );

endmodule

// ----- hw/rtl/vss_checker.sv -----
// Port-level assertions for the slot signature scanner, bound to the top level.
`timescale 1ns / 1ps

module vss_checker
    import vss_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [ADDR_W-1:0] slot_base,
    input logic [ADDR_W-1:0] mask_addr,
    input logic [ADDR_W-1:0] dest_addr,
    input logic [ADDR_W-1:0] value_addr,
    input logic [ADDR_W-1:0] modifier_addr,
    input logic              final_of_item
);

    // Hold a stalled beat.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(slot_base) && $stable(final_of_item))
        else $error("output beat changed while stalled");

    a_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> mask_addr == slot_base + MASK_OFS)
        else $error("mask_addr does not track slot_base");

    a_dest_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (dest_addr == slot_base + DEST_OFS) &&
                      (value_addr == slot_base + VALUE_OFS))
        else $error("dest or value address does not track slot_base");

    a_modifier: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> modifier_addr == slot_base + MODIFIER_OFS)
        else $error("modifier_addr does not track slot_base");

    // A non-final beat is the first of a pair: its partner is one slot later.
    a_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !final_of_item |=>
            out_valid && (slot_base == $past(slot_base) + ADDR_W'(SLOT_BYTES)))
        else $error("second slot of a run start missing or misplaced");

endmodule

bind var_slot_signature_scanner_top vss_checker u_vss_checker (.*);
